[rtl/eim_pkg.sv]
// Shared constants, codes and controller/datapath command types for the
// exon interval merge block. No dependencies.
`default_nettype none

package eim_pkg;

  localparam int MAX_EXONS       = 64;
  localparam int MAX_TRANSCRIPTS = 32;
  localparam int WINDOW          = 4096;
  localparam int MAX_RESULTS     = 64;

  localparam int COORD_W = 31;
  localparam int BASES_W = 32;
  localparam int EXON_AW = $clog2(MAX_EXONS);
  localparam int EXON_CW = $clog2(MAX_EXONS + 1);
  localparam int OWN_W   = $clog2(MAX_TRANSCRIPTS);
  localparam int TX_CW   = $clog2(MAX_TRANSCRIPTS + 1);
  localparam int WIN_AW  = $clog2(WINDOW);
  localparam int RES_CW  = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_LONGEST   = 2'd0;
  localparam logic [1:0] MODE_UNION     = 2'd1;
  localparam logic [1:0] MODE_INTERSECT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SPAN  = 2'd1;
  localparam logic [1:0] ST_TABLE = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_exon;
    logic k_clr;
    logic k_inc;
    logic b_clr;
    logic b_inc;
    logic clr_wr;
    logic paint_set;
    logic cov_rd;
    logic paint_wr;
    logic scan_step;
    logic take_long;
    logic take_scan;
    logic emit_err;
    logic emit_last;
    logic clear_gene;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic mode_long;
    logic bounds_empty;
    logic span_big;
    logic k_last;
    logic b_last;
    logic b_at_end;
    logic ex_empty;
    logic own_match;
    logic take_req;
    logic blocked;
    logic can_emit;
    logic pend_vld;
  } sts_t;

endpackage

`default_nettype wire

[rtl/eim_ifs.sv]
// Valid/ready channel interfaces for the exon interval merge block:
// exon input, merged run output and mode configuration. No dependencies.
`default_nettype none

interface eim_exon_if;
  logic        valid;
  logic        ready;
  logic [30:0] exon_start;
  logic [30:0] exon_end;
  logic        transcript_done;
  logic        gene_done;

  modport source (output valid, exon_start, exon_end, transcript_done, gene_done,
                  input ready);
  modport sink (input valid, exon_start, exon_end, transcript_done, gene_done,
                output ready);
endinterface

interface eim_run_if;
  logic        valid;
  logic        ready;
  logic [30:0] run_start;
  logic [30:0] run_end;
  logic        last_run;
  logic [1:0]  status;

  modport source (output valid, run_start, run_end, last_run, status, input ready);
  modport sink (input valid, run_start, run_end, last_run, status, output ready);
endinterface

interface eim_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] merge_mode;

  modport source (output valid, merge_mode, input ready);
  modport sink (input valid, merge_mode, output ready);
endinterface

`default_nettype wire

[rtl/eim_dp.sv]
// Datapath: exon tables, gene bounds and base counts, coverage and mark
// memories, run tracking and the output register. Uses eim_pkg.
`default_nettype none

module eim_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire eim_pkg::cmd_t                   cmd,
  output eim_pkg::sts_t                        sts,
  input  wire logic [eim_pkg::COORD_W-1:0]     exon_start,
  input  wire logic [eim_pkg::COORD_W-1:0]     exon_end,
  input  wire logic                            transcript_done,
  input  wire logic                            gene_done,
  input  wire logic                            cfg_valid,
  input  wire logic [1:0]                      cfg_mode,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [eim_pkg::COORD_W-1:0]          run_start,
  output logic [eim_pkg::COORD_W-1:0]          run_end,
  output logic                                 last_run,
  output logic [1:0]                           status
);

  localparam int CW = eim_pkg::COORD_W;
  localparam int BW = eim_pkg::BASES_W;
  localparam int AW = eim_pkg::EXON_AW;
  localparam int ECW = eim_pkg::EXON_CW;
  localparam int OW = eim_pkg::OWN_W;
  localparam int TW = eim_pkg::TX_CW;
  localparam int WW = eim_pkg::WIN_AW;
  localparam int RW = eim_pkg::RES_CW;

  logic [1:0] mode;

  logic [CW-1:0] start_mem [eim_pkg::MAX_EXONS];
  logic [CW-1:0] end_mem   [eim_pkg::MAX_EXONS];
  logic [OW-1:0] owner_mem [eim_pkg::MAX_EXONS];
  logic [CW-1:0] rd_start, rd_end;
  logic [OW-1:0] rd_owner;

  logic [TW-1:0] cov_mem  [eim_pkg::WINDOW];
  logic [TW-1:0] mark_mem [eim_pkg::WINDOW];
  logic [TW-1:0] rd_cov, rd_mark;

  logic [ECW-1:0] exon_total;
  logic [TW-1:0]  tx_total;
  logic [CW-1:0]  low, high;
  logic [BW-1:0]  running, best_bases;
  logic [OW-1:0]  best_tx;
  logic           ovf;

  logic [AW-1:0] k;
  logic [WW-1:0] b, bend, run_from;
  logic          in_run;

  logic          pend_vld;
  logic [CW-1:0] pend_lo, pend_hi;
  logic [RW-1:0] run_cnt;

  logic          store;
  logic          ex_ok;
  logic [BW:0]   sum;
  logic [BW-1:0] run_new;
  logic          close_tx;
  logic [CW-1:0] span_m1;
  logic [TW-1:0] tag;
  logic          cov;
  logic [WW-1:0] from_sel;
  logic [CW-1:0] sc_lo, sc_hi, new_lo, new_hi;
  logic          can_emit, take_go, emit_pend, emit_fin;
  logic          room;

  // Mode loads whenever cfg_valid is high; the top gates it with idle ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= eim_pkg::MODE_UNION;
    end else if (cfg_valid) begin
      mode <= cfg_mode;
    end
  end

  assign store = cmd.load && !ovf
                 && exon_total < ECW'(eim_pkg::MAX_EXONS)
                 && tx_total < TW'(eim_pkg::MAX_TRANSCRIPTS);
  assign ex_ok    = exon_end >= exon_start;
  assign sum      = {1'b0, running} + (ex_ok ? (BW + 1)'(exon_end - exon_start) + 1'b1
                                             : '0);
  assign run_new  = sum[BW] ? '1 : sum[BW-1:0];
  assign close_tx = transcript_done || gene_done;

  always_ff @(posedge clk) begin
    if (store) begin
      start_mem[exon_total[AW-1:0]] <= exon_start;
      end_mem[exon_total[AW-1:0]]   <= exon_end;
      owner_mem[exon_total[AW-1:0]] <= tx_total[OW-1:0];
    end
    if (cmd.rd_exon) begin
      rd_start <= start_mem[k];
      rd_end   <= end_mem[k];
      rd_owner <= owner_mem[k];
    end
  end

  assign tag = TW'(rd_owner) + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cov_mem[b]  <= '0;
      mark_mem[b] <= '0;
    end else if (cmd.paint_wr && rd_mark != tag) begin
      cov_mem[b]  <= rd_cov + 1'b1;
      mark_mem[b] <= tag;
    end
    if (cmd.cov_rd) begin
      rd_cov  <= cov_mem[b];
      rd_mark <= mark_mem[b];
    end
  end

  assign span_m1  = high - low;
  assign cov      = (mode == eim_pkg::MODE_INTERSECT) ? (rd_cov == tx_total)
                                                      : (rd_cov != '0);
  assign from_sel = in_run ? run_from : b;
  assign sc_lo    = low + CW'(from_sel);
  assign sc_hi    = cov ? high : low + CW'(b) - 1'b1;
  assign new_lo   = cmd.take_long ? rd_start : sc_lo;
  assign new_hi   = cmd.take_long ? rd_end : sc_hi;

  assign can_emit  = !out_valid || out_ready;
  assign room      = run_cnt < RW'(eim_pkg::MAX_RESULTS);
  assign take_go   = (cmd.take_long || cmd.take_scan) && room;
  assign emit_pend = take_go && pend_vld;
  assign emit_fin  = cmd.emit_last && pend_vld;

  always_comb begin
    sts.ovf          = ovf;
    sts.mode_long    = mode == eim_pkg::MODE_LONGEST;
    sts.bounds_empty = high < low;
    sts.span_big     = span_m1 >= CW'(eim_pkg::WINDOW);
    sts.k_last       = ECW'(k) == exon_total - 1'b1;
    sts.b_last       = b == span_m1[WW-1:0];
    sts.b_at_end     = b == bend;
    sts.ex_empty     = rd_end < rd_start;
    sts.own_match    = rd_owner == best_tx;
    sts.take_req     = (cov && sts.b_last) || (!cov && in_run);
    sts.blocked      = pend_vld && room && !can_emit;
    sts.can_emit     = can_emit;
    sts.pend_vld     = pend_vld;
  end

  // Per-gene state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_gene) begin
      exon_total <= '0;
      tx_total   <= '0;
      low        <= '1;
      high       <= '0;
      running    <= '0;
      best_bases <= '0;
      best_tx    <= '0;
      ovf        <= 1'b0;
      pend_vld   <= 1'b0;
      run_cnt    <= '0;
    end else begin
      if (cmd.load && !ovf && !store) begin
        ovf <= 1'b1;
      end
      if (store) begin
        exon_total <= exon_total + 1'b1;
        if (ex_ok && exon_start < low) begin
          low <= exon_start;
        end
        if (ex_ok && exon_end > high) begin
          high <= exon_end;
        end
        if (close_tx) begin
          if (run_new > best_bases) begin
            best_bases <= run_new;
            best_tx    <= tx_total[OW-1:0];
          end
          tx_total <= tx_total + 1'b1;
          running  <= '0;
        end else begin
          running <= run_new;
        end
      end
      if (take_go) begin
        pend_vld <= 1'b1;
        pend_lo  <= new_lo;
        pend_hi  <= new_hi;
        run_cnt  <= run_cnt + 1'b1;
      end
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
    if (cmd.b_clr) begin
      b      <= '0;
      in_run <= 1'b0;
    end else begin
      if (cmd.paint_set) begin
        b    <= WW'(rd_start - low);
        bend <= WW'(rd_end - low);
      end else if (cmd.b_inc) begin
        b <= b + 1'b1;
      end
      if (cmd.scan_step) begin
        if (cov && !in_run) begin
          in_run   <= 1'b1;
          run_from <= b;
        end else if (!cov && in_run) begin
          in_run <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_err || emit_pend || emit_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      run_start <= '0;
      run_end   <= '0;
      last_run  <= 1'b1;
      status    <= ovf ? eim_pkg::ST_TABLE : eim_pkg::ST_SPAN;
    end else if (emit_pend || emit_fin) begin
      run_start <= pend_lo;
      run_end   <= pend_hi;
      last_run  <= emit_fin;
      status    <= eim_pkg::ST_OK;
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= RW'(eim_pkg::MAX_RESULTS))
    else $error("run count past result limit");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != eim_pkg::ST_OK |-> last_run)
    else $error("error result not marked last");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_err || emit_pend || emit_fin) |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

  a_gene_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_gene |=> exon_total == '0 && !pend_vld && !ovf)
    else $error("gene state not cleared");

endmodule

`default_nettype wire

[rtl/eim_ctrl.sv]
// Controller state machine: exon loading, then the longest-transcript walk or
// the clear/paint/scan passes over the coverage window. Uses eim_pkg.
`default_nettype none

module eim_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_gene_done,
  output logic               in_ready,
  output eim_pkg::cmd_t      cmd,
  input  wire eim_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_ERR    = 4'd2;
  localparam logic [3:0] S_FIN    = 4'd3;
  localparam logic [3:0] S_L_RD   = 4'd4;
  localparam logic [3:0] S_L_EV   = 4'd5;
  localparam logic [3:0] S_CLR    = 4'd6;
  localparam logic [3:0] S_P_RD   = 4'd7;
  localparam logic [3:0] S_P_SET  = 4'd8;
  localparam logic [3:0] S_B_RD   = 4'd9;
  localparam logic [3:0] S_B_WR   = 4'd10;
  localparam logic [3:0] S_S_RD   = 4'd11;
  localparam logic [3:0] S_S_EV   = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_gene_done) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cmd.k_clr = 1'b1;
        if (sts.ovf) begin
          state_next = S_ERR;
        end else if (sts.mode_long) begin
          state_next = S_L_RD;
        end else if (sts.bounds_empty) begin
          state_next = S_FIN;
        end else if (sts.span_big) begin
          state_next = S_ERR;
        end else begin
          cmd.b_clr  = 1'b1;
          state_next = S_CLR;
        end
      end
      S_ERR: begin
        if (sts.can_emit) begin
          cmd.emit_err   = 1'b1;
          cmd.clear_gene = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FIN: begin
        if (!(sts.pend_vld && !sts.can_emit)) begin
          cmd.emit_last  = 1'b1;
          cmd.clear_gene = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_L_RD: begin
        cmd.rd_exon = 1'b1;
        state_next  = S_L_EV;
      end
      S_L_EV: begin
        if (!(sts.own_match && sts.blocked)) begin
          cmd.take_long = sts.own_match;
          if (sts.k_last) begin
            state_next = S_FIN;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_L_RD;
          end
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.b_last) begin
          state_next = S_P_RD;
        end else begin
          cmd.b_inc = 1'b1;
        end
      end
      S_P_RD: begin
        cmd.rd_exon = 1'b1;
        state_next  = S_P_SET;
      end
      S_P_SET: begin
        if (!sts.ex_empty) begin
          cmd.paint_set = 1'b1;
          state_next    = S_B_RD;
        end else if (sts.k_last) begin
          cmd.b_clr  = 1'b1;
          state_next = S_S_RD;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_P_RD;
        end
      end
      S_B_RD: begin
        cmd.cov_rd = 1'b1;
        state_next = S_B_WR;
      end
      S_B_WR: begin
        cmd.paint_wr = 1'b1;
        if (!sts.b_at_end) begin
          cmd.b_inc  = 1'b1;
          state_next = S_B_RD;
        end else if (sts.k_last) begin
          cmd.b_clr  = 1'b1;
          state_next = S_S_RD;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_P_RD;
        end
      end
      S_S_RD: begin
        cmd.cov_rd = 1'b1;
        state_next = S_S_EV;
      end
      S_S_EV: begin
        if (!(sts.take_req && sts.blocked)) begin
          cmd.scan_step = 1'b1;
          cmd.take_scan = sts.take_req;
          if (sts.b_last) begin
            state_next = S_FIN;
          end else begin
            cmd.b_inc  = 1'b1;
            state_next = S_S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/exon_interval_merge.sv]
// Top level of the exon interval merge block: joins controller and datapath
// to the channel interfaces. Uses eim_pkg, eim_ifs, eim_ctrl and eim_dp.
`default_nettype none

// Exons load one per cycle while the block is idle. The exon flagged
// gene_done starts the merge. The input and the mode port stall until the
// gene's last item, if any, has been loaded into the output register.
// Longest mode walks the stored exons, reading then evaluating each. Union
// and intersection first clear the coverage and mark memories over the
// gene span, then paint every exon base by base with a read and a write,
// then scan the span with a read and an evaluation per base. A decide
// state and a finish state come on top, and output back-pressure can
// stall the walk, the scan and the last item. A gene with table overflow
// or, outside longest mode, a span over 4096 bases yields one error item.

module exon_interval_merge (
  input  wire logic  clk,
  input  wire logic  rst,
  eim_cfg_if.sink    cfg,
  eim_exon_if.sink   exons,
  eim_run_if.source  runs
);

  eim_pkg::cmd_t cmd;
  eim_pkg::sts_t sts;

  // Mode writes only while loading, never during a merge.
  assign cfg.ready = exons.ready;

  eim_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (exons.valid),
    .in_gene_done (exons.gene_done),
    .in_ready     (exons.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  eim_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .exon_start      (exons.exon_start),
    .exon_end        (exons.exon_end),
    .transcript_done (exons.transcript_done),
    .gene_done       (exons.gene_done),
    .cfg_valid       (cfg.valid && cfg.ready),
    .cfg_mode        (cfg.merge_mode),
    .out_ready       (runs.ready),
    .out_valid       (runs.valid),
    .run_start       (runs.run_start),
    .run_end         (runs.run_end),
    .last_run        (runs.last_run),
    .status          (runs.status)
  );

endmodule

`default_nettype wire

[dv/exon_interval_merge_tb.sv]
// Self-checking testbench for exon_interval_merge: directed gene table, then
// random genes in every merge mode, checked against a behavioral predictor.
// Depends on rtl/eim_pkg.sv, rtl/eim_ifs.sv and rtl/exon_interval_merge.sv.
`default_nettype none

module exon_interval_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [30:0] MAXC = 31'h7FFF_FFFF;
  localparam int SETTLE_CYC = 40000;
  localparam bit [1:0] MODE_SPARE = 2'd3;   // unused code, behaves as union

  typedef struct {
    bit [30:0] s;
    bit [30:0] e;
    bit        td;
    bit        gd;
    bit        hx;   // typed expectation follows
    bit [30:0] xs;
    bit [30:0] xe;
    bit [1:0]  xst;
  } exon_item_t;

  typedef struct packed {
    bit [30:0] s;
    bit [30:0] e;
    bit        last;
    bit [1:0]  st;
  } run_t;

  typedef struct {
    bit [1:0]  mode;
    bit [30:0] s;
    bit [30:0] e;
    bit        td;
    bit        gd;
    bit        hx;
    bit [30:0] xs;
    bit [30:0] xe;
    bit [1:0]  xst;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  eim_cfg_if  cfg ();
  eim_exon_if exons ();
  eim_run_if  runs ();

  exon_interval_merge dut (.clk(clk), .rst(rst), .cfg(cfg), .exons(exons), .runs(runs));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  exon_item_t cur;
  logic [1:0] cfg_data = eim_pkg::MODE_UNION;
  initial begin
    exons.valid = 1'b0;
    cfg.valid   = 1'b0;
    runs.ready  = 1'b0;
    cur = '{default: 0};
  end
  assign exons.exon_start      = cur.s;
  assign exons.exon_end        = cur.e;
  assign exons.transcript_done = cur.td;
  assign exons.gene_done       = cur.gd;
  assign cfg.merge_mode        = cfg_data;

  // ---------------- predictor state ----------------
  bit [1:0]  mode_q;
  bit [30:0] start_tab [eim_pkg::MAX_EXONS];
  bit [30:0] end_tab   [eim_pkg::MAX_EXONS];
  int        owner_tab [eim_pkg::MAX_EXONS];
  int        n_exons, n_tx, best_tx;
  bit [30:0] low_b, high_b;
  bit [31:0] run_bases, best_bases;
  bit        tab_ovf;
  int        depth_cnt [eim_pkg::WINDOW];
  int        mark_tab  [eim_pkg::WINDOW];
  run_t      merged_q [$];   // expected runs, oldest first
  run_t      gene_runs [$];

  int mismatches = 0, results_seen = 0, items_sent = 0, genes_sent = 0;

  function automatic void clear_gene_state();
    n_exons = 0; n_tx = 0; best_tx = 0;
    low_b = MAXC; high_b = 0;
    run_bases = 0; best_bases = 0;
    tab_ovf = 0;
  endfunction

  function automatic void add_run(bit [30:0] lo, bit [30:0] hi);
    if (gene_runs.size() < eim_pkg::MAX_RESULTS)
      gene_runs.push_back('{lo, hi, 1'b0, eim_pkg::ST_OK});
  endfunction

  function automatic void scan_coverage(bit need_all);
    longint span, b, from;
    bit in_run, hit;
    for (int i = 0; i < eim_pkg::WINDOW; i++) begin
      depth_cnt[i] = 0;
      mark_tab[i] = 0;
    end
    if (high_b < low_b) return;
    span = longint'(high_b) - longint'(low_b) + 1;
    for (int k = 0; k < n_exons; k++) begin
      if (end_tab[k] < start_tab[k]) continue;
      for (b = longint'(start_tab[k]) - low_b; b <= longint'(end_tab[k]) - low_b && b < span;
           b++) begin
        if (mark_tab[b] != owner_tab[k] + 1) begin
          mark_tab[b] = owner_tab[k] + 1;
          depth_cnt[b]++;
        end
      end
    end
    in_run = 0;
    from = 0;
    for (b = 0; b < span; b++) begin
      hit = need_all ? (depth_cnt[b] == n_tx) : (depth_cnt[b] != 0);
      if (hit && !in_run) begin
        in_run = 1;
        from = b;
      end else if (!hit && in_run) begin
        in_run = 0;
        add_run(31'(low_b + from), 31'(low_b + b - 1));
      end
    end
    if (in_run) add_run(31'(low_b + from), high_b);
  endfunction

  function automatic void predict_exon(exon_item_t it);
    longint sum;
    if (!tab_ovf) begin
      if (n_exons >= eim_pkg::MAX_EXONS || n_tx >= eim_pkg::MAX_TRANSCRIPTS) begin
        tab_ovf = 1;
      end else begin
        start_tab[n_exons] = it.s;
        end_tab[n_exons] = it.e;
        owner_tab[n_exons] = n_tx;
        n_exons++;
        if (it.e >= it.s) begin
          sum = longint'(run_bases) + longint'(it.e - it.s) + 1;
          run_bases = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
          if (it.s < low_b) low_b = it.s;
          if (it.e > high_b) high_b = it.e;
        end
        if (it.td || it.gd) begin
          if (run_bases > best_bases) begin
            best_bases = run_bases;
            best_tx = n_tx;
          end
          n_tx++;
          run_bases = 0;
        end
      end
    end
    if (!it.gd) return;
    gene_runs.delete();
    if (tab_ovf) begin
      gene_runs.push_back('{31'd0, 31'd0, 1'b1, eim_pkg::ST_TABLE});
    end else if (mode_q == eim_pkg::MODE_LONGEST) begin
      for (int k = 0; k < n_exons; k++)
        if (owner_tab[k] == best_tx) add_run(start_tab[k], end_tab[k]);
    end else if (high_b >= low_b && longint'(high_b - low_b) + 1 > eim_pkg::WINDOW) begin
      gene_runs.push_back('{31'd0, 31'd0, 1'b1, eim_pkg::ST_SPAN});
    end else begin
      scan_coverage(mode_q == eim_pkg::MODE_INTERSECT);
    end
    if (gene_runs.size() > 0) gene_runs[gene_runs.size() - 1].last = 1'b1;
    if (it.hx) begin
      gene_runs.delete();
      gene_runs.push_back('{it.xs, it.xe, 1'b1, it.xst});
    end
    foreach (gene_runs[i]) merged_q.push_back(gene_runs[i]);
    clear_gene_state();
  endfunction

  // ---------------- sampling at the rising edge ----------------
  logic in_fire = 1'b0, cfg_fire = 1'b0;
  always @(posedge clk) begin
    run_t got, want;
    in_fire  <= exons.valid && exons.ready;
    cfg_fire <= cfg.valid && cfg.ready;
    if (!rst) begin
      if (cfg.valid && cfg.ready) mode_q = cfg.merge_mode;
      if (exons.valid && exons.ready) predict_exon(cur);
      if (runs.valid && runs.ready) begin
        got = '{runs.run_start, runs.run_end, runs.last_run, runs.status};
        results_seen++;
        if (merged_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected run: start %0d end %0d last %0b status %0d",
                     got.s, got.e, got.last, got.st);
        end else begin
          want = merged_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("run mismatch: expected %0d..%0d last %0b st %0d, %s",
                       want.s, want.e, want.last, want.st,
                       $sformatf("got %0d..%0d last %0b st %0d",
                                 got.s, got.e, got.last, got.st));
          end
        end
      end
    end
  end

  // ---------------- receiver ----------------
  logic hold_req = 1'b0;
  initial begin
    int hold_left, pat, pat_left;
    hold_left = 0; pat = 0; pat_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) hold_left = 1500;
      if (hold_left > 0) begin
        runs.ready <= 1'b0;
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          pat = $urandom_range(0, 2);
          pat_left = $urandom_range(5, 60);
        end
        pat_left--;
        case (pat)
          0: runs.ready <= 1'b1;
          1: runs.ready <= 1'($urandom_range(0, 1));
          default: runs.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------- sender ----------------
  int burst_left = 0;
  exon_item_t gene_q [$];

  // valid stays high through a burst; it drops when the burst ends or the
  // sender is stopped, and a new burst starts only after an idle gap
  task automatic send_exon(exon_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    exons.valid <= 1'b1;
    cur <= it;
    do @(negedge clk); while (!in_fire);
    burst_left--;
    if (burst_left == 0) exons.valid <= 1'b0;
    items_sent++;
    if (it.gd) genes_sent++;
  endtask

  task automatic stop_sending();
    if (burst_left != 0) begin
      exons.valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  // wait for the block to drain, including genes that produce nothing
  task automatic settle();
    stop_sending();
    while (merged_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_mode(bit [1:0] m);
    settle();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg_data <= m;
    do @(negedge clk); while (!cfg_fire);
    cfg.valid <= 1'b0;
  endtask

  function automatic exon_item_t mk(bit [30:0] s, bit [30:0] e, bit td, bit gd);
    mk = '{s, e, td, gd, 1'b0, 31'd0, 31'd0, eim_pkg::ST_OK};
  endfunction

  function automatic void build_gene();
    int kind, ntx, nex, n;
    bit [30:0] base, s;
    gene_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // table overflow: too many exons or too many transcripts
      n = $urandom_range(0, 1) ? eim_pkg::MAX_EXONS + 1 : eim_pkg::MAX_TRANSCRIPTS + 1;
      for (int i = 0; i < n; i++)
        gene_q.push_back(mk(31'($urandom), 31'($urandom),
                            (n == eim_pkg::MAX_TRANSCRIPTS + 1), i == n - 1));
    end else if (kind == 1) begin
      // noise: unrelated full-range coordinates
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        gene_q.push_back(mk(31'($urandom), 31'($urandom), 1'($urandom), i == n - 1));
    end else if (kind == 2) begin
      // span right at the window, or one base past it
      base = 31'($urandom_range(0, 32'h7FFF_0000));
      gene_q.push_back(mk(base, base, 1'b1, 1'b0));
      s = 31'(base + eim_pkg::WINDOW - 1 + $urandom_range(0, 1));
      gene_q.push_back(mk(s, s, 1'($urandom), 1'b1));
    end else begin
      base = 31'($urandom);
      if (base > MAXC - 400) base = $urandom_range(0, 1) ? MAXC - 200 : base - 400;
      ntx = $urandom_range(1, 4);
      for (int t = 0; t < ntx; t++) begin
        nex = $urandom_range(1, 4);
        for (int x = 0; x < nex; x++) begin
          s = 31'(base + $urandom_range(0, 150));
          if ($urandom_range(0, 15) == 0)
            gene_q.push_back(mk(s, 31'(s - $urandom_range(1, 5)), x == nex - 1, 1'b0));
          else
            gene_q.push_back(mk(s, 31'(s + $urandom_range(0, 40)), x == nex - 1, 1'b0));
        end
      end
      gene_q[gene_q.size() - 1].gd = 1'b1;
      gene_q[gene_q.size() - 1].td = 1'($urandom);
    end
  endfunction

  dir_row_t dir_tab [] = '{
    '{eim_pkg::MODE_UNION, 31'd0, 31'd0, 1, 1, 1, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_UNION, 31'd10, 31'd20, 1, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_UNION, 31'd15, 31'd30, 1, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    // empty exon only
    '{eim_pkg::MODE_UNION, 31'd50, 31'd40, 1, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_UNION, 31'd0, 31'd0, 1, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_UNION, 31'd4096, 31'd4096, 0, 1, 1, 31'd0, 31'd0, eim_pkg::ST_SPAN},
    '{eim_pkg::MODE_UNION, MAXC - 5, MAXC, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_UNION, MAXC - 9, MAXC - 7, 1, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_LONGEST, 31'd0, MAXC, 1, 1, 1, 31'd0, MAXC, eim_pkg::ST_OK},
    // saturating counts
    '{eim_pkg::MODE_LONGEST, 31'd0, MAXC, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_LONGEST, 31'd0, MAXC, 1, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_LONGEST, 31'd5, 31'd6, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_LONGEST, 31'd0, MAXC, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_LONGEST, 31'd9, 31'd3, 0, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_INTERSECT, 31'd10, 31'd20, 1, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_INTERSECT, 31'd15, 31'd30, 0, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{eim_pkg::MODE_INTERSECT, 31'd1, 31'd2, 1, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    // no common base
    '{eim_pkg::MODE_INTERSECT, 31'd5, 31'd6, 1, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    // spare mode code acts as union
    '{MODE_SPARE, 31'd100, 31'd105, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{MODE_SPARE, 31'd103, 31'd110, 0, 0, 0, 31'd0, 31'd0, eim_pkg::ST_OK},
    '{MODE_SPARE, 31'd200, 31'd200, 1, 1, 0, 31'd0, 31'd0, eim_pkg::ST_OK}
  };

  bit [1:0] phase_modes [] = '{eim_pkg::MODE_UNION, eim_pkg::MODE_LONGEST,
                                eim_pkg::MODE_INTERSECT, MODE_SPARE,
                                eim_pkg::MODE_LONGEST, eim_pkg::MODE_INTERSECT,
                                eim_pkg::MODE_UNION};

  initial begin
    bit [1:0] cur_mode;
    exon_item_t it;
    int phase_items;
    bit drained;
    mode_q = eim_pkg::MODE_UNION;
    clear_gene_state();
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    cur_mode = eim_pkg::MODE_UNION;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != cur_mode) begin
        write_mode(dir_tab[i].mode);
        cur_mode = dir_tab[i].mode;
      end
      it = '{dir_tab[i].s, dir_tab[i].e, dir_tab[i].td, dir_tab[i].gd,
             dir_tab[i].hx, dir_tab[i].xs, dir_tab[i].xe, dir_tab[i].xst};
      send_exon(it);
    end

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      phase_items = 0;
      if (p == 1) hold_req = 1'b1;   // long output hold-off while exons keep coming
      while (phase_items < 36) begin
        build_gene();
        foreach (gene_q[i]) send_exon(gene_q[i]);
        phase_items += gene_q.size();
        hold_req = 1'b0;
        if (p == 2 && phase_items > 20 && !drained) begin
          drained = 1'b1;
          stop_sending();
          while (merged_q.size() != 0) @(negedge clk);
        end
      end
    end

    settle();
    $display("Covered %0d exons in %0d genes across all merge modes, %0d runs checked.",
             items_sent, genes_sent, results_seen);
    if (mismatches == 0 && merged_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d runs never arrived", mismatches, merged_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d runs outstanding", merged_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[exon_interval_merge.f]
rtl/eim_pkg.sv
rtl/eim_ifs.sv
rtl/eim_dp.sv
rtl/eim_ctrl.sv
rtl/exon_interval_merge.sv
dv/exon_interval_merge_tb.sv
